// ===== hdl/tbc_pkg.sv =====
// Shared types and constants for the thermistor beta converter.
`timescale 1ns / 1ps
package tbc_pkg;

  localparam int unsigned AdcBits = 12;
  localparam logic [AdcBits-1:0] AdcFs = AdcBits'((64'd1 << AdcBits) - 64'd1);

  localparam int unsigned LogFrac = 24;
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;
  localparam logic [39:0] InvT0Q40 = 40'(((64'd1 << 40) * 64'd100 + 64'd14907) / 64'd29815);
  localparam logic [11:0] ClampRatio = 12'd3299;
  localparam logic signed [17:0] TempMin = -18'sd27315;
  localparam logic signed [17:0] TempMax = 18'sd100000;
  localparam logic [16:0] TckMax = 17'd127315;

  // light divide by full scale as a reciprocal multiply, exact for 26-bit dividends
  localparam int unsigned LightShift = 38;
  localparam logic [31:0] LightRecip =
    32'(((64'd1 << LightShift) + 64'(AdcFs) - 64'd1) / 64'(AdcFs));

  localparam int unsigned ProdW = 40;
  localparam int unsigned ExpW = 6;
  localparam int unsigned LogW = ExpW + LogFrac;

  typedef enum logic [1:0] {
    CfgBeta   = 2'd0,
    CfgSeries = 2'd1,
    CfgNom    = 2'd2
  } cfg_idx_e;

  // One squaring round of the log2 fraction search.
  typedef struct packed {
    logic [32:0] m;
    logic [LogFrac-1:0] frac;
  } log_step_t;

  function automatic log_step_t log_round(log_step_t s);
    logic [65:0] sq;
    log_step_t r;
    sq = 66'(s.m) * 66'(s.m);
    r.m = 33'(sq >> 31);
    r.frac = {s.frac[LogFrac-2:0], 1'b0};
    if (r.m[32]) begin
      r.m = r.m >> 1;
      r.frac[0] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/thermistor_beta_to_celsius_top.sv =====
// Top level: thermistor beta-equation temperature and light level pipeline.
//
//  channel | signals                                  | direction
//  in      | in_valid_i in_ready_o therm/light_code_i | sink
//  out     | out_valid_o out_ready_i reading/temp/... | source
//  cfg     | cfg_we_i cfg_index_i cfg_data_i          | sink, no back-pressure
//
// Stage order: clamp and products, log2, ln2 product, ln/beta divide, 1/T, reciprocal
// divide, output register; the two dividers resolve one bit per stage and the log2
// pipeline runs one squaring round per stage.
// One sample pair enters per cycle unless the output stalls. An output stall freezes the
// whole pipeline (no bubble squeeze); in_ready_o follows out_ready_i or an empty output slot.
// Reset clears valid bits and restores the default registers.
`timescale 1ns / 1ps
module thermistor_beta_to_celsius_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [11:0] therm_code_i,
  input  logic [11:0] light_code_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic reading_ok_o,
  output logic signed [17:0] temp_centi_c_o,
  output logic [13:0] light_centi_pct_o,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import tbc_pkg::*;

  localparam logic [11:0] Fs = 12'(AdcFs);
  localparam int unsigned LogLat = LogFrac + 1;
  localparam int unsigned D1W = 61;
  localparam int unsigned D2W = 48;
  localparam int unsigned D2NumW = 48;
  localparam int unsigned Lat1 = 2 + LogLat;

  // tag carries ok, neg, light through divider 1
  localparam int unsigned TagW = 16;

  // stages: Lat1, ln2 product, divider 1, 1/T, divider 2, output
  localparam int unsigned Total = Lat1 + 1 + (D1W + 1) + 1 + (D2NumW + 1) + 1;

  logic [13:0] beta_q;
  logic [19:0] rs_q, r0_q;
  logic en;
  logic [Total-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= 14'd3950;
      rs_q <= 20'd10000;
      r0_q <= 20'd10000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBeta:   beta_q <= cfg_data_i[13:0];
        CfgSeries: rs_q <= cfg_data_i;
        CfgNom:    r0_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Total-2:0], in_valid_i};
  end
  assign out_valid_o = vld_q[Total-1];

  // Stage A: ratio clamp, light product
  logic [11:0] tc, lc, n_d, d_d;
  logic rail_d;
  logic [11:0] n_q, d_q;
  logic ok_q;
  logic [25:0] lprod_q;
  always_comb begin
    tc = therm_code_i & Fs;
    lc = light_code_i & Fs;
    rail_d = (tc == '0) || (tc == Fs);
    n_d = Fs - tc;
    d_d = tc;
    if (24'(n_d) > 24'(ClampRatio) * 24'(d_d)) begin
      n_d = ClampRatio; d_d = 12'd1;
    end else if (24'(ClampRatio) * 24'(n_d) < 24'(d_d)) begin
      n_d = 12'd1; d_d = ClampRatio;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q <= n_d;
      d_q <= d_d;
      ok_q <= !rail_d;
      lprod_q <= 26'(lc) * 26'd10000 + 26'(Fs >> 1);
    end
  end

  // Stage B: resistance products, light divide by full scale via reciprocal
  logic [ProdW-1:0] pa_q, pb_q;
  logic ok_b_q;
  logic [13:0] light_b_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= ProdW'((rs_q == '0 ? 20'd1 : rs_q)) * ProdW'(n_q);
      pb_q <= ProdW'((r0_q == '0 ? 20'd1 : r0_q)) * ProdW'(d_q);
      ok_b_q <= ok_q;
      light_b_q <= 14'((58'(lprod_q) * 58'(LightRecip)) >> LightShift);
    end
  end

  logic [LogW-1:0] la, lb;
  tbc_log2 u_log_a (.clk_i, .rst_ni, .en_i(en), .x_i(pa_q), .log_o(la));
  tbc_log2 u_log_b (.clk_i, .rst_ni, .en_i(en), .x_i(pb_q), .log_o(lb));

  logic ok_l_q [LogLat];
  logic [13:0] light_l_q [LogLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_l_q[0] <= ok_b_q;
      light_l_q[0] <= light_b_q;
      for (int i = 1; i < LogLat; i++) begin
        ok_l_q[i] <= ok_l_q[i-1];
        light_l_q[i] <= light_l_q[i-1];
      end
    end
  end

  // Stage C: |la-lb| * ln2
  logic [D1W-1:0] mprod_q;
  logic neg_q, ok_c_q;
  logic [13:0] light_c_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q <= la < lb;
      mprod_q <= D1W'((la < lb) ? lb - la : la - lb) * D1W'(Ln2Q32);
      ok_c_q <= ok_l_q[LogLat-1];
      light_c_q <= light_l_q[LogLat-1];
    end
  end

  logic [D1W-1:0] q1;
  logic [TagW-1:0] tag1;
  tbc_div #(.NumW(D1W), .DenW(14), .TagW(TagW)) u_div_beta (
    .clk_i, .rst_ni, .en_i(en), .num_i(mprod_q),
    .den_i(beta_q == '0 ? 14'd1 : beta_q),
    .tag_i({ok_c_q, neg_q, light_c_q}), .quo_o(q1), .tag_o(tag1)
  );

  // Stage D: 1/T in Q40
  logic signed [D2W:0] invt_d;
  logic signed [D2W:0] invt_q;
  logic [TagW-1:0] tag_d_q;
  assign invt_d = tag1[14] ? $signed({9'd0, InvT0Q40}) - $signed({1'b0, D2W'(q1 >> 16)})
                           : $signed({9'd0, InvT0Q40}) + $signed({1'b0, D2W'(q1 >> 16)});
  always_ff @(posedge clk_i) begin
    if (en) begin
      invt_q <= invt_d;
      tag_d_q <= tag1;
    end
  end

  logic [D2NumW-1:0] q2;
  logic [D2W-1:0] den2;
  logic [TagW+1:0] tag2;
  assign den2 = invt_q[D2W-1:0];
  tbc_div #(.NumW(D2NumW), .DenW(D2W), .TagW(TagW+2)) u_div_inv (
    .clk_i, .rst_ni, .en_i(en),
    .num_i((D2NumW'(100) << 40) + D2NumW'(den2 >> 1)),
    .den_i(den2 == '0 ? D2W'(1) : den2),
    .tag_i({invt_q[D2W], den2 == '0, tag_d_q}), .quo_o(q2), .tag_o(tag2)
  );

  // Stage E: saturate, output register
  logic signed [17:0] temp_d;
  logic [13:0] light_o_d;
  logic ok_d;
  always_comb begin
    ok_d = tag2[15];
    light_o_d = tag2[13:0];
    if (tag2[17]) temp_d = TempMin;
    else if (tag2[16]) temp_d = TempMax;
    else if (q2 > D2NumW'(TckMax)) temp_d = TempMax;
    else temp_d = $signed(18'(q2)) - 18'sd27315;
    if (!ok_d) begin
      temp_d = '0;
      light_o_d = '0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      reading_ok_o <= ok_d;
      temp_centi_c_o <= temp_d;
      light_centi_pct_o <= light_o_d;
    end
  end
endmodule

// ===== hdl/tbc_log2.sv =====
// Pipelined fixed-point log2: normalize stage then one squaring round per stage.
`timescale 1ns / 1ps
module tbc_log2 (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic [tbc_pkg::ProdW-1:0] x_i,
  output logic [tbc_pkg::LogW-1:0] log_o
);
  import tbc_pkg::*;

  localparam int unsigned Stages = LogFrac;

  logic [ExpW-1:0] exp_d;
  logic [32:0] man_d;
  logic [ExpW-1:0] exp_q [Stages+1];
  log_step_t st_q [Stages+1];

  always_comb begin
    logic [ProdW-1:0] x;
    x = (x_i == '0) ? ProdW'(1) : x_i;
    exp_d = '0;
    for (int i = 0; i < ProdW; i++) begin
      if (x[i]) exp_d = ExpW'(i);
    end
    if (exp_d <= ExpW'(31)) man_d = 33'(x << (31 - exp_d));
    else man_d = 33'(x >> (exp_d - ExpW'(31)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Stages; i++) begin
        exp_q[i] <= '0;
        st_q[i] <= '0;
      end
    end else if (en_i) begin
      exp_q[0] <= exp_d;
      st_q[0] <= '{m: man_d, frac: '0};
      for (int i = 1; i <= Stages; i++) begin
        exp_q[i] <= exp_q[i-1];
        st_q[i] <= log_round(st_q[i-1]);
      end
    end
  end

  assign log_o = {exp_q[Stages], st_q[Stages].frac};
endmodule

// ===== hdl/tbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tbc_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 40,
  parameter int unsigned TagW = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic [NumW-1:0] quo_o,
  output logic [TagW-1:0] tag_o
);
  logic [NumW-1:0] num_q [NumW+1];
  logic [DenW:0]   rem_q [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];
  logic [TagW-1:0] tag_q [NumW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NumW; i++) begin
        num_q[i] <= '0;
        rem_q[i] <= '0;
        den_q[i] <= '0;
        tag_q[i] <= '0;
      end
    end else if (en_i) begin
      num_q[0] <= num_i;
      rem_q[0] <= '0;
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
      for (int i = 1; i <= NumW; i++) begin
        logic [DenW+1:0] t;
        t = {rem_q[i-1], num_q[i-1][NumW-1]};
        den_q[i] <= den_q[i-1];
        tag_q[i] <= tag_q[i-1];
        if (t >= {2'b00, den_q[i-1]}) begin
          rem_q[i] <= (DenW+1)'(t - {2'b00, den_q[i-1]});
          num_q[i] <= {num_q[i-1][NumW-2:0], 1'b1};
        end else begin
          rem_q[i] <= (DenW+1)'(t);
          num_q[i] <= {num_q[i-1][NumW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = num_q[NumW];
  assign tag_o = tag_q[NumW];
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the thermistor beta / light level converter.
`timescale 1ns / 1ps
module testbench;
  import tbc_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait = 200;
  localparam logic [11:0] CodeFull = 12'hFFF;

  typedef struct packed {
    logic ok;
    logic signed [17:0] temp;
    logic [13:0] light;
  } reading_t;

  class reading_board;
    reading_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function void note_transfer(reading_t r);
      pending.push_back(r);
    endfunction

    function void check_result(reading_t got);
      reading_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result ok=%0d temp=%0d light=%0d",
                                   got.ok, got.temp, got.light);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp ok=%0d temp=%0d light=%0d, got ok=%0d temp=%0d light=%0d",
                   want.ok, want.temp, want.light, got.ok, got.temp, got.light);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [11:0] therm_code_i, light_code_i;
  logic out_valid_o, out_ready_i;
  logic reading_ok_o;
  logic signed [17:0] temp_centi_c_o;
  logic [13:0] light_centi_pct_o;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [19:0] cfg_data_i;

  thermistor_beta_to_celsius_top u_dut (.*);

  reading_board board = new();
  logic [13:0] beta_reg;
  logic [19:0] series_reg, nominal_reg;
  int unsigned cycles, sent, burst_left;
  int unsigned rx_mode, rx_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned log2_fixed(longint unsigned x);
    longint unsigned e, m, frac;
    e = 0;
    frac = 0;
    if (x == 0) x = 1;
    while ((x >> e) > 1) e++;
    m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
    for (int i = 0; i < LogFrac; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (e << LogFrac) | frac;
  endfunction

  function automatic reading_t convert_sample(logic [11:0] tc, logic [11:0] lc);
    reading_t r;
    longint unsigned rs, r0, beta, n, d, la, lb, mag, p, q, tck;
    longint invt, temp;
    bit neg;
    r = '0;
    if (tc == 0 || tc == CodeFull) return r;
    rs = series_reg ? series_reg : 1;
    r0 = nominal_reg ? nominal_reg : 1;
    beta = beta_reg ? beta_reg : 1;
    n = CodeFull - tc;
    d = tc;
    if (n > 3299 * d) begin
      n = 3299;
      d = 1;
    end else if (3299 * n < d) begin
      n = 1;
      d = 3299;
    end
    la = log2_fixed(rs * n);
    lb = log2_fixed(r0 * d);
    neg = la < lb;
    mag = neg ? lb - la : la - lb;
    p = ((mag * 64'd2977044472) / beta) >> 16;
    invt = neg ? longint'(InvT0Q40) - longint'(p) : longint'(InvT0Q40) + longint'(p);
    if (invt < 0) temp = -27315;
    else if (invt == 0) temp = 100000;
    else begin
      q = invt;
      tck = ((64'd100 << 40) + q / 2) / q;
      temp = (tck > 127315) ? 100000 : longint'(tck) - 27315;
      if (temp < -27315) temp = -27315;
    end
    r.ok = 1'b1;
    r.temp = temp[17:0];
    r.light = 14'((longint'(lc) * 10000 + 2047) / 4095);
    return r;
  endfunction

  // Receiver: stall pattern picks at random among always-ready, random and long-stall modes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_result({reading_ok_o, temp_centi_c_o, light_centi_pct_o});
      if (rx_left == 0) begin
        rx_mode = $urandom_range(2);
        rx_left = $urandom_range(200, 20);
      end else rx_left--;
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(1);
        default: out_ready_i <= ($urandom_range(9) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_sample(logic [11:0] tc, logic [11:0] lc);
    in_valid_i <= 1'b1;
    therm_code_i <= tc;
    light_code_i <= lc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_transfer(convert_sample(tc, lc));
    sent++;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
      burst_left = $urandom_range(40, 1);
    end else burst_left--;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [19:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgBeta: beta_reg = value[13:0];
      CfgSeries: series_reg = value;
      CfgNom: nominal_reg = value;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [13:0] b, logic [19:0] rs, logic [19:0] r0, int unsigned count);
    drain_results();
    write_reg(CfgBeta, {6'($urandom), b});
    write_reg(CfgSeries, rs);
    write_reg(CfgNom, r0);
    // index past the register list must leave the registers alone
    cfg_we_i <= 1'b1;
    cfg_index_i <= 2'd3;
    cfg_data_i <= 20'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      case ($urandom_range(9))
        0: send_sample($urandom_range(1) ? 12'd0 : CodeFull, 12'($urandom));
        1: send_sample(12'($urandom_range(3, 1)), 12'($urandom));
        2: send_sample(12'($urandom_range(4094, 4091)), 12'($urandom));
        default: send_sample(12'($urandom), 12'($urandom));
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    therm_code_i = '0;
    light_code_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    beta_reg = 14'd3950;
    series_reg = 20'd10000;
    nominal_reg = 20'd10000;
    cycles = 0;
    sent = 0;
    burst_left = 0;
    rx_mode = 0;
    rx_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rails, clamp edges, light extremes, at reset settings
    send_sample(12'd0, 12'd4095);
    send_sample(CodeFull, 12'd4095);
    send_sample(12'd1, 12'd0);
    send_sample(12'd4094, 12'd4095);
    send_sample(12'd2, 12'd2047);
    send_sample(12'd2048, 12'd2048);
    send_sample(12'd2047, 12'hAAA);
    send_sample(12'd1241, 12'h555);
    send_sample(12'd3000, 12'd1);
    send_sample(12'd100, 12'd4094);

    run_phase(14'd3950, 20'd10000, 20'd10000, 180);
    run_phase(14'd1000, 20'd100, 20'd1000000, 180);
    run_phase(14'd10000, 20'd1000000, 20'd100, 180);
    run_phase(14'd0, 20'd0, 20'd0, 100);
    run_phase(14'h3FFF, 20'hFFFFF, 20'd47000, 180);
    run_phase(14'd3435, 20'd4700, 20'd100000, 180);

    drain_results();
    $display("%0d samples sent, %0d results checked over six register settings",
             sent, board.checked);
    $display("rail, clamp, zero-register and saturation cases included; %0d errors",
             board.errors + board.pending.size());
    if (board.errors == 0 && board.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tbc_pkg.sv
hdl/tbc_log2.sv
hdl/tbc_div.sv
hdl/thermistor_beta_to_celsius_top.sv
verif/testbench.sv
